FILE: src/sitoa_pkg.sv
package sitoa_pkg;

  // Default operand width
  localparam int unsigned DataWidthDef = 32;

  // ASCII character width and codes
  localparam int unsigned CharW = 7;
  localparam logic [CharW-1:0] CHAR_ZERO  = 7'd48;
  localparam logic [CharW-1:0] CHAR_MINUS = 7'd45;

  // BCD digit width
  localparam int unsigned DigitW = 4;

  // Control of the serial BCD register
  typedef struct packed {
    logic clear;   // zero all digits
    logic dabble;  // add-3 correction, then shift in bit_in
    logic bit_in;  // next magnitude bit, MSB first
    logic drain;   // shift out the top digit
  } bcd_ctrl_t;

endpackage

FILE: src/sitoa_bcd.sv
module sitoa_bcd
  import sitoa_pkg::*;
#(
  parameter int unsigned NUM_DIGITS = 10
) (
  input  logic              clk_i,
  input  bcd_ctrl_t         ctrl_i,
  output logic [DigitW-1:0] top_digit_o
);

  localparam int unsigned BcdW = DigitW * NUM_DIGITS;

  logic [BcdW-1:0] bcd_q;
  logic [BcdW-1:0] bcd_d;
  logic [BcdW-1:0] adj;

  // Add 3 to every digit of five or more before the shift
  for (genvar i = 0; i < NUM_DIGITS; i++) begin : g_adj
    logic [DigitW-1:0] dig;
    assign dig = bcd_q[DigitW*i +: DigitW];
    assign adj[DigitW*i +: DigitW] = (dig >= 4'd5) ? (dig + 4'd3) : dig;
  end

  // Select the next register contents
  always_comb begin
    bcd_d = bcd_q;
    if (ctrl_i.clear) begin
      bcd_d = '0;
    end else if (ctrl_i.dabble) begin
      bcd_d = {adj[BcdW-2:0], ctrl_i.bit_in};
    end else if (ctrl_i.drain) begin
      bcd_d = {bcd_q[BcdW-DigitW-1:0], {DigitW{1'b0}}};
    end
  end

  always_ff @(posedge clk_i) begin
    bcd_q <= bcd_d;
  end

  assign top_digit_o = bcd_q[BcdW-1 -: DigitW];

endmodule

FILE: src/signed_int_to_decimal_ascii.sv
// Signed integer to decimal ASCII text.
//
// Input channel: in_valid_i / in_stall_o with value_i, a two's complement
// integer of DATA_WIDTH bits. Output channel: out_valid_o / out_stall_i with
// one ASCII character per transaction on character_o, most significant first:
// '-' for a negative value, then the digits without leading zeros ("0" for
// zero). last_o marks the final character of each value.
//
// The magnitude is turned into BCD by a bit-serial double-dabble register,
// one input bit per cycle, then the BCD register drains one digit per cycle
// while the receiver does not stall, with leading zeros dropped and the sign
// sent before the digits. Without a sign, each leading zero dropped delays
// the first character. One value is in work at a time; the input stalls
// until its last character enters the output register.
// A receiver stall holds the output register and pauses character emission;
// conversion and leading-zero dropping go on. Reset clears the sequencer and
// the output valid; no transaction is lost other than those in progress.
module signed_int_to_decimal_ascii
  import sitoa_pkg::*;
#(
  parameter int unsigned DATA_WIDTH = DataWidthDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [DATA_WIDTH-1:0] value_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [CharW-1:0]      character_o,
  output logic                  last_o
);

  localparam int unsigned NumDigits = ((DATA_WIDTH - 1) * 30103) / 100000 + 1;
  localparam int unsigned CntW      = $clog2(DATA_WIDTH);
  localparam int unsigned DigCntW   = $clog2(NumDigits);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StConv = 2'd1;
  localparam logic [1:0] StSign = 2'd2;
  localparam logic [1:0] StEmit = 2'd3;

  logic [1:0]            state_q, state_d;
  logic [CntW-1:0]       cnt_q, cnt_d;
  logic [DigCntW-1:0]    dig_q, dig_d;
  logic                  neg_q, neg_d;
  logic                  started_q, started_d;
  logic [DATA_WIDTH-1:0] mag_q, mag_d;
  logic                  out_valid_q, out_valid_d;
  logic [CharW-1:0]      char_q, char_d;
  logic                  last_q, last_d;
  logic                  out_free;
  bcd_ctrl_t             bcd_ctrl;
  logic [DigitW-1:0]     top_digit;

  sitoa_bcd #(
    .NUM_DIGITS(NumDigits)
  ) u_bcd (
    .clk_i      (clk_i),
    .ctrl_i     (bcd_ctrl),
    .top_digit_o(top_digit)
  );

  // Output register can take a new character
  assign out_free = !out_valid_q || !out_stall_i;

  // Sequence conversion and character emission
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    dig_d       = dig_q;
    neg_d       = neg_q;
    started_d   = started_q;
    mag_d       = mag_q;
    out_valid_d = out_valid_q && out_stall_i;
    char_d      = char_q;
    last_d      = last_q;
    bcd_ctrl    = '0;

    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          neg_d         = value_i[DATA_WIDTH-1];
          mag_d         = value_i[DATA_WIDTH-1] ? (~value_i + 1'b1) : value_i;
          cnt_d         = CntW'(DATA_WIDTH - 1);
          bcd_ctrl.clear = 1'b1;
          state_d       = StConv;
        end
      end
      StConv: begin
        bcd_ctrl.dabble = 1'b1;
        bcd_ctrl.bit_in = mag_q[DATA_WIDTH-1];
        mag_d           = {mag_q[DATA_WIDTH-2:0], 1'b0};
        cnt_d           = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          dig_d     = DigCntW'(NumDigits - 1);
          started_d = 1'b0;
          state_d   = neg_q ? StSign : StEmit;
        end
      end
      StSign: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          char_d      = CHAR_MINUS;
          last_d      = 1'b0;
          state_d     = StEmit;
        end
      end
      StEmit: begin
        if (!started_q && (top_digit == '0) && (dig_q != '0)) begin
          // drop a leading zero
          bcd_ctrl.drain = 1'b1;
          dig_d          = dig_q - 1'b1;
        end else if (out_free) begin
          out_valid_d    = 1'b1;
          char_d         = CHAR_ZERO + {{(CharW-DigitW){1'b0}}, top_digit};
          last_d         = (dig_q == '0);
          bcd_ctrl.drain = 1'b1;
          started_d      = 1'b1;
          dig_d          = dig_q - 1'b1;
          if (dig_q == '0) begin
            state_d = StIdle;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // Hold control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cnt_q       <= '0;
      dig_q       <= '0;
      neg_q       <= 1'b0;
      started_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      dig_q       <= dig_d;
      neg_q       <= neg_d;
      started_q   <= started_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Hold payload
  always_ff @(posedge clk_i) begin
    mag_q  <= mag_d;
    char_q <= char_d;
    last_q <= last_d;
  end

  assign in_stall_o  = (state_q != StIdle);
  assign out_valid_o = out_valid_q;
  assign character_o = char_q;
  assign last_o      = last_q;

endmodule
